>>> hw/rtl/jet_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Julia escape-time pixel block.
// No dependencies.
package jet_pkg;

  localparam int IMG_LOG2   = 9;
  localparam int IMAGE_SIZE = 1 << IMG_LOG2;
  localparam int PIX_W      = IMG_LOG2;
  localparam int FRAC_BITS  = 28;
  localparam int Z_W        = 32;
  localparam int ZN_W       = 30;
  localparam int CNT_W      = 8;
  localparam int TAG_W      = 2;
  localparam int MAP_W      = IMG_LOG2 + 34;
  localparam int NXT_W      = 40;
  localparam int MAG_W      = 2 * ZN_W + 1;

  localparam logic signed [31:0] SCALE_K2 = 32'sd912680550;

  localparam int PADDR_W = 4;

  typedef enum logic [1:0] {
    REG_C_REAL = 2'd0,
    REG_C_IMAG = 2'd1,
    REG_LIMIT  = 2'd2,
    REG_NONE   = 2'd3
  } jet_reg_t;

  typedef struct packed {
    logic             vld;
    logic             done;
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] k;
    logic [CNT_W-1:0] cnt;
    logic             no_esc;
  } jet_meta_t;

endpackage

>>> hw/rtl/jet_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixel and result beats.
// Depends on jet_pkg.
interface jet_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [jet_pkg::PIX_W-1:0] pixel_x;
  logic [jet_pkg::PIX_W-1:0] pixel_y;
  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface jet_result_if;
  logic                      valid;
  logic                      ready;
  logic [jet_pkg::CNT_W-1:0] escape_count;
  logic                      never_escaped;
  modport source (output valid, output escape_count, output never_escaped, input ready);
  modport sink (input valid, input escape_count, input never_escaped, output ready);
endinterface

>>> hw/rtl/julia_escape_time_pixel.sv
`timescale 1ns / 1ps
// Julia escape-time evaluator, top level.
// Depends on jet_pkg and the channel interfaces in jet_if.sv.
//
// One iteration z = z^2 + c is one pass around a three-stage ring
// (products, shift/add with magnitude-bound test, squared-magnitude test);
// up to three pixels circulate in the ring at once. A pixel makes one pass
// per iteration until it escapes or reaches the iteration limit (a single
// pass for a zero limit), so the iteration limit sets the worst case.
// Results leave in input order: a finished pixel keeps circulating until it
// is the oldest and the output register is free.
// A new pixel enters when the ring slot coming around is empty or its pixel exits.
module julia_escape_time_pixel (
  input  logic                        clk,
  input  logic                        rst_n,
  jet_pixel_if.sink                   in_px,
  jet_result_if.source                out_res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jet_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import jet_pkg::*;

  logic signed [31:0] c_real_r, c_imag_r;
  logic [CNT_W-1:0]   limit_r;
  jet_reg_t           reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] > 2'd2) ? REG_NONE : jet_reg_t'(paddr[3:2]);

  always_comb begin
    unique case (reg_sel)
      REG_C_REAL: prdata = c_real_r;
      REG_C_IMAG: prdata = c_imag_r;
      REG_LIMIT:  prdata = {24'd0, limit_r};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_real_r <= '0;
      c_imag_r <= '0;
      limit_r  <= 8'd255;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_C_REAL: c_real_r <= pwdata;
        REG_C_IMAG: c_imag_r <= pwdata;
        REG_LIMIT:  limit_r  <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // coordinate mapping
  function automatic logic signed [31:0] map_coord(input logic [PIX_W-1:0] p);
    logic signed [IMG_LOG2+1:0] diff;
    logic signed [MAP_W-1:0]    num;
    logic signed [MAP_W-1:0]    q;
    diff = $signed({1'b0, p, 1'b0}) - $signed((IMG_LOG2+2)'(IMAGE_SIZE));
    num  = MAP_W'(diff) * MAP_W'(SCALE_K2) + MAP_W'(IMAGE_SIZE);
    q    = num >>> (IMG_LOG2 + 1);
    if (q > MAP_W'(32'sh7fffffff))
      return 32'sh7fffffff;
    else if (q < -MAP_W'(64'sh80000000))
      return 32'sh80000000;
    else
      return q[31:0];
  endfunction

  jet_meta_t               m0_r, m1_r, m2_r, mc;
  logic signed [Z_W-1:0]   re_r, im_r, re_nxt, im_nxt;
  logic signed [63:0]      rr_r, ii_r, ri_r;
  logic signed [ZN_W-1:0]  nre_r, nim_r;
  logic                    part_r;
  logic [TAG_W-1:0]        in_seq_r, out_seq_r;
  logic                    out_valid_r;
  logic [CNT_W-1:0]        out_cnt_r;
  logic                    out_inside_r;
  jet_meta_t               m0_nxt;

  logic signed [64:0]      dsub;
  logic signed [NXT_W-1:0] nre_f, nim_f;
  logic signed [MAG_W-1:0] mag;
  logic                    esc, out_free, exit_now, fb_vld, in_acc;

  // stage B combinational
  assign dsub  = 65'(rr_r) - 65'(ii_r);
  assign nre_f = NXT_W'(dsub >>> FRAC_BITS) + NXT_W'(c_real_r);
  assign nim_f = NXT_W'(ri_r >>> (FRAC_BITS - 1)) + NXT_W'(c_imag_r);

  // stage C combinational
  assign mag = MAG_W'(nre_r * nre_r) + MAG_W'(nim_r * nim_r);
  assign esc = part_r || (mag >= (MAG_W'(1) <<< 58));

  always_comb begin
    mc = m2_r;
    if (m2_r.vld && !m2_r.done) begin
      if (esc) begin
        mc.done = 1'b1; mc.cnt = m2_r.k; mc.no_esc = 1'b0;
      end else if (m2_r.k == limit_r) begin
        mc.done = 1'b1; mc.cnt = limit_r; mc.no_esc = 1'b1;
      end else begin
        mc.k = m2_r.k + 8'd1;
      end
    end
  end

  assign out_free = !out_valid_r || out_res.ready;
  assign exit_now = mc.vld && mc.done && (mc.tag == out_seq_r) && out_free;
  assign fb_vld   = mc.vld && !exit_now;
  assign in_px.ready = !fb_vld;
  assign in_acc   = in_px.valid && !fb_vld;

  always_comb begin
    m0_nxt = mc;
    re_nxt = Z_W'(nre_r);
    im_nxt = Z_W'(nim_r);
    if (!fb_vld) begin
      m0_nxt.vld    = in_acc;
      m0_nxt.tag    = in_seq_r;
      m0_nxt.k      = 8'd1;
      m0_nxt.done   = (limit_r == 8'd0);
      m0_nxt.cnt    = 8'd0;
      m0_nxt.no_esc = 1'b1;
      re_nxt        = map_coord(in_px.pixel_x);
      im_nxt        = map_coord(in_px.pixel_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m0_r.vld    <= 1'b0;
      m1_r.vld    <= 1'b0;
      m2_r.vld    <= 1'b0;
      in_seq_r    <= '0;
      out_seq_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      m0_r <= m0_nxt;
      m1_r <= m0_r;
      m2_r <= m1_r;
      if (in_acc)
        in_seq_r <= in_seq_r + 2'd1;
      if (exit_now) begin
        out_seq_r   <= out_seq_r + 2'd1;
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    re_r   <= re_nxt;
    im_r   <= im_nxt;
    rr_r   <= 64'(re_r) * 64'(re_r);
    ii_r   <= 64'(im_r) * 64'(im_r);
    ri_r   <= 64'(re_r) * 64'(im_r);
    part_r <= (nre_f >= (NXT_W'(1) <<< 29)) || (nre_f <= -(NXT_W'(1) <<< 29)) ||
              (nim_f >= (NXT_W'(1) <<< 29)) || (nim_f <= -(NXT_W'(1) <<< 29));
    nre_r  <= nre_f[ZN_W-1:0];
    nim_r  <= nim_f[ZN_W-1:0];
    if (exit_now) begin
      out_cnt_r    <= mc.cnt;
      out_inside_r <= mc.no_esc;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.escape_count  = out_cnt_r;
  assign out_res.never_escaped = out_inside_r;

endmodule

>>> sim/tb_julia_escape_time_pixel.sv
`timescale 1ns / 1ps
// Testbench for julia_escape_time_pixel: directed and random pixel beats and APB register writes,
// results checked in order against an in-bench escape-time predictor.
// Depends on jet_pkg, jet_if.sv and the block RTL.
module tb_julia_escape_time_pixel;
  import jet_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0] escape_count;
    logic             never_escaped;
  } escape_res_t;

  class escape_scoreboard;
    escape_res_t pending_q[$];
    logic signed [31:0] c_re;
    logic signed [31:0] c_im;
    logic [7:0] lim;
    int errors;

    function new();
      c_re = 0;
      c_im = 0;
      lim = 8'd255;
      errors = 0;
    endfunction

    function logic signed [63:0] map_pixel(logic [PIX_W-1:0] p);
      logic signed [63:0] num;
      logic signed [63:0] q;
      num = 64'sd2 * 64'sd456340275 * (64'sd2 * $signed({55'd0, p}) - IMAGE_SIZE)
            + IMAGE_SIZE;
      q = num / (2 * IMAGE_SIZE);
      if (num % (2 * IMAGE_SIZE) != 0 && num < 0) q = q - 1;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
      logic signed [63:0] re;
      logic signed [63:0] im;
      logic signed [63:0] nre;
      logic signed [63:0] nim;
      escape_res_t r;
      bit esc;
      re = map_pixel(px);
      im = map_pixel(py);
      r.escape_count = lim;
      r.never_escaped = 1'b1;
      for (int k = 1; k <= lim; k++) begin
        nre = ((re * re - im * im) >>> 28) + c_re;
        nim = ((re * im) >>> 27) + c_im;
        esc = nre >= (64'sd1 <<< 29) || nre <= -(64'sd1 <<< 29) ||
              nim >= (64'sd1 <<< 29) || nim <= -(64'sd1 <<< 29);
        if (!esc) esc = (nre * nre + nim * nim) >= (64'sd1 <<< 58);
        if (esc) begin
          r.escape_count = k[7:0];
          r.never_escaped = 1'b0;
          break;
        end
        re = nre;
        im = nim;
      end
      pending_q.insert(pending_q.size(), r);
    endfunction

    function void check_result(logic [CNT_W-1:0] cnt, logic ne);
      escape_res_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat escape_count=%0d never_escaped=%0d", cnt, ne);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (cnt !== e.escape_count) begin
        $error("escape_count expected %0d actual %0d", e.escape_count, cnt);
        errors++;
      end
      if (ne !== e.never_escaped) begin
        $error("never_escaped expected %0d actual %0d", e.never_escaped, ne);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int cycles = 0;
  bit hold_sink = 1'b0;
  escape_scoreboard sb = new();

  jet_pixel_if in_px();
  jet_result_if out_res();

  julia_escape_time_pixel u_dut (
    .clk(clk), .rst_n(rst_n), .in_px(in_px.sink), .out_res(out_res.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    in_px.valid = 1'b0;
    in_px.pixel_x = '0;
    in_px.pixel_y = '0;
    out_res.ready = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_res.valid && out_res.ready)
      sb.check_result(out_res.escape_count, out_res.never_escaped);
  end

  // sink: random stall per beat, with a forced long hold when requested
  initial begin
    int w;
    @(posedge clk iff rst_n);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (w > 0 || hold_sink) begin
        out_res.ready <= 1'b0;
        repeat (w) @(posedge clk);
        while (hold_sink) @(posedge clk);
      end
      out_res.ready <= 1'b1;
      @(posedge clk iff out_res.valid);
    end
  end

  task automatic reg_write(jet_reg_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * idx);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk iff pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_C_REAL: sb.c_re = val;
      REG_C_IMAG: sb.c_im = val;
      REG_LIMIT: sb.lim = val[7:0];
      default: ;
    endcase
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py, int gap);
    if (gap > 0) begin
      in_px.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_px.valid <= 1'b1;
    in_px.pixel_x <= px;
    in_px.pixel_y <= py;
    @(posedge clk iff in_px.ready);
    sb.note_pixel(px, py);
  endtask

  task automatic drain();
    in_px.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_pixels(int n, bit gaps);
    int g;
    for (int i = 0; i < n; i++) begin
      g = (gaps && $urandom_range(0, 2) != 0) ? $urandom_range(0, 14) : 0;
      if ($urandom_range(0, 3) == 0)
        send_pixel(PIX_W'($urandom_range(0, 511)), PIX_W'($urandom_range(0, 511)), g);
      else
        send_pixel(PIX_W'($urandom_range(200, 312)), PIX_W'($urandom_range(200, 312)), g);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corners, center, limit extremes, several constants
    reg_write(REG_LIMIT, 32'd255);
    send_pixel(9'd0, 9'd0, 0);
    send_pixel(9'd511, 9'd511, 0);
    send_pixel(9'd256, 9'd256, 0);
    send_pixel(9'd0, 9'd511, 0);
    send_pixel(9'd511, 9'd0, 0);
    send_pixel(9'd256, 9'd200, 0);
    drain();
    reg_write(REG_C_REAL, 32'hF3333333); // -0.8
    reg_write(REG_C_IMAG, 32'h028F5C29); // 0.16
    send_pixel(9'd256, 9'd256, 0);
    send_pixel(9'd300, 9'd240, 0);
    send_pixel(9'd170, 9'd400, 0);
    drain();
    reg_write(REG_LIMIT, 32'd1);
    send_pixel(9'd256, 9'd256, 0);
    send_pixel(9'd0, 9'd0, 0);
    send_pixel(9'd100, 9'd300, 0);
    drain();
    reg_write(REG_LIMIT, 32'd0);
    send_pixel(9'd256, 9'd256, 0);
    send_pixel(9'd0, 9'd511, 0);
    drain();
    reg_write(REG_C_REAL, 32'h7FFFFFFF);
    reg_write(REG_C_IMAG, 32'h80000000);
    reg_write(REG_LIMIT, 32'd3);
    send_pixel(9'd256, 9'd256, 0);
    send_pixel(9'd511, 9'd0, 0);
    drain();

    // random phases over several constants and limits
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(REG_C_REAL, (ph % 3 == 0) ? $urandom() : $urandom_range(0, 32'h0CCCCCCC)
                - 32'h06666666);
      reg_write(REG_C_IMAG, (ph % 3 == 0) ? $urandom() : $urandom_range(0, 32'h0CCCCCCC)
                - 32'h06666666);
      reg_write(REG_LIMIT, (ph == 2) ? 32'd255 : (ph == 5) ? 32'd1 : $urandom_range(1, 64));
      if (ph == 3) begin
        hold_sink = 1'b1;
        fork
          begin
            repeat (600) @(posedge clk);
            hold_sink = 1'b0;
          end
        join_none
        random_pixels(20, 1'b0);
      end
      random_pixels(70, ph != 4);
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

>>> files.f
hw/rtl/jet_pkg.sv
hw/rtl/jet_if.sv
hw/rtl/julia_escape_time_pixel.sv
sim/tb_julia_escape_time_pixel.sv
